[design/command_line_assembler_assert.svh]
// Assertion macros for the top file of the command line assembler.
`ifndef COMMAND_LINE_ASSEMBLER_ASSERT_SVH
`define COMMAND_LINE_ASSEMBLER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CLA_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/cla_pkg.sv]
`timescale 1ns / 1ps

package cla_pkg;

    localparam int BYTE_W = 8;
    localparam int LINE_BYTES_DEFAULT = 64;

    localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;

    // Strobes from the controller to the line store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

endpackage

[design/cla_line_ram.sv]
`timescale 1ns / 1ps

module cla_line_ram #(
    parameter int LINE_BYTES = cla_pkg::LINE_BYTES_DEFAULT,
    localparam int AW = $clog2(LINE_BYTES)
) (
    input  logic                      aclk,
    input  cla_pkg::ram_ctl_t         ram_ctl,
    input  logic [AW-1:0]             ram_addr,
    input  logic [cla_pkg::BYTE_W-1:0] ram_wr_data,
    output logic [cla_pkg::BYTE_W-1:0] ram_rd_data
);

    logic [cla_pkg::BYTE_W-1:0] mem [LINE_BYTES];
    logic [cla_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (ram_ctl.wr_en) begin
            mem[ram_addr] <= ram_wr_data;
        end
        if (ram_ctl.rd_en) begin
            rd_data_reg <= mem[ram_addr];
        end
    end

    assign ram_rd_data = rd_data_reg;

endmodule

[design/cla_ctrl.sv]
`timescale 1ns / 1ps

module cla_ctrl #(
    parameter int LINE_BYTES = cla_pkg::LINE_BYTES_DEFAULT,
    localparam int AW = $clog2(LINE_BYTES)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [cla_pkg::BYTE_W-1:0] s_rx_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [cla_pkg::BYTE_W-1:0] m_line_byte,
    output logic                       m_line_end,
    output cla_pkg::ram_ctl_t          ram_ctl,
    output logic [AW-1:0]              ram_addr,
    output logic [cla_pkg::BYTE_W-1:0] ram_wr_data,
    input  logic [cla_pkg::BYTE_W-1:0] ram_rd_data
);

    localparam logic [AW-1:0] Limit = AW'(LINE_BYTES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PUSH,
        ST_TERM
    } state_t;

    state_t                     state_reg, state_next;
    logic [AW-1:0]              pos_reg, pos_next;
    logic [AW-1:0]              rd_idx_reg, rd_idx_next;
    logic [cla_pkg::BYTE_W-1:0] term_reg, term_next;
    logic                       out_valid_reg, out_valid_next;
    logic [cla_pkg::BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic                       out_end_reg, out_end_next;
    logic                       out_free;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        rd_idx_next    = rd_idx_reg;
        term_next      = term_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        out_end_next   = out_end_reg;
        ram_ctl        = '0;
        ram_addr       = pos_reg;
        ram_wr_data    = s_rx_byte;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (pos_reg >= Limit) begin
                        // Store holds LINE_BYTES-1 bytes: the byte is dropped and the line restarts.
                        pos_next = '0;
                    end else begin
                        unique case (s_rx_byte) inside
                            cla_pkg::CH_NEWLINE, cla_pkg::CH_RETURN: begin
                                term_next   = s_rx_byte;
                                rd_idx_next = '0;
                                state_next  = (pos_reg == '0) ? ST_TERM : ST_FETCH;
                            end
                            cla_pkg::CH_BACKSPACE: begin
                                if (pos_reg != '0) begin
                                    pos_next = pos_reg - AW'(1);
                                end
                            end
                            default: begin
                                ram_ctl.wr_en = 1'b1;
                                pos_next      = pos_reg + AW'(1);
                            end
                        endcase
                    end
                end
            end
            ST_FETCH: begin
                ram_ctl.rd_en = 1'b1;
                ram_addr      = rd_idx_reg;
                state_next    = ST_PUSH;
            end
            ST_PUSH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = ram_rd_data;
                    out_end_next   = 1'b0;
                    if (rd_idx_reg == pos_reg - AW'(1)) begin
                        state_next = ST_TERM;
                    end else begin
                        rd_idx_next = rd_idx_reg + AW'(1);
                        state_next  = ST_FETCH;
                    end
                end
            end
            ST_TERM: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = term_reg;
                    out_end_next   = 1'b1;
                    pos_next       = '0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
        rd_idx_reg   <= rd_idx_next;
        term_reg     <= term_next;
        out_byte_reg <= out_byte_next;
        out_end_reg  <= out_end_next;
    end

    assign m_valid     = out_valid_reg;
    assign m_line_byte = out_byte_reg;
    assign m_line_end  = out_end_reg;

endmodule

[design/command_line_assembler.sv]
`timescale 1ns / 1ps
// Channel | Direction | Ports                          | Meaning
// s_      | in        | s_valid s_ready s_rx_byte      | one received character
// m_      | out       | m_valid m_ready m_line_byte    | one byte of a finished line,
//         |           | m_line_end                     | m_line_end marks the terminator
// An ordinary byte or a backspace is accepted while idle and yields no transaction.
// A terminator is accepted while idle; then each stored byte is read from the line store
// in ST_FETCH and loaded into the output register in ST_PUSH, then the terminator is
// loaded in ST_TERM. Stalls on m_ready stretch this one load at a time, until the
// output register is free.
// Reset clears the state, the position and the output valid flag; the line store keeps no reset value.

module command_line_assembler #(
    parameter int LINE_BYTES = cla_pkg::LINE_BYTES_DEFAULT
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [cla_pkg::BYTE_W-1:0] s_rx_byte,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [cla_pkg::BYTE_W-1:0] m_line_byte,
    output logic                       m_line_end
);

`include "command_line_assembler_assert.svh"

    localparam int AW = $clog2(LINE_BYTES);

    // The controller writes the store only while idle and reads it only while
    // draining a line, so a read and a write of the same entry can never meet.
    cla_pkg::ram_ctl_t          ram_ctl;
    logic [AW-1:0]              ram_addr;
    logic [cla_pkg::BYTE_W-1:0] ram_wr_data;
    logic [cla_pkg::BYTE_W-1:0] ram_rd_data;

    cla_ctrl #(
        .LINE_BYTES (LINE_BYTES)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_line_byte (m_line_byte),
        .m_line_end  (m_line_end),
        .ram_ctl     (ram_ctl),
        .ram_addr    (ram_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_data (ram_rd_data)
    );

    cla_line_ram #(
        .LINE_BYTES (LINE_BYTES)
    ) u_line_ram (
        .aclk        (aclk),
        .ram_ctl     (ram_ctl),
        .ram_addr    (ram_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_data (ram_rd_data)
    );

    // The store is written only by an accepted input transaction.
    `CLA_ASSERT_IMPLY(a_wr_on_accept, aclk, aresetn, ram_ctl.wr_en, s_valid && s_ready, "store written without an accepted byte")

    // No input is taken while the line is being read out.
    `CLA_ASSERT_IMPLY(a_no_accept_in_read, aclk, aresetn, ram_ctl.rd_en, !s_ready, "input accepted during read-out")

    // A store read is always followed by a cycle that is not ready for input.
    `CLA_ASSERT_NEXT(a_read_then_busy, aclk, aresetn, ram_ctl.rd_en, !s_ready && !ram_ctl.rd_en, "read not followed by its load cycle")

endmodule
